>>> rtl/ip6tp_pkg.sv
// Shared types and constants for the IPv6 text address parser.
package ip6tp_pkg;

	// Address geometry
	localparam int unsigned NUM_GROUPS  = 8;
	localparam int unsigned GROUP_W     = 16;
	localparam int unsigned GIDX_W      = 4;   // holds 0..NUM_GROUPS
	localparam int unsigned HALF_GROUPS = NUM_GROUPS / 2;

	// Character-queue depth between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Prefix limits
	localparam logic [7:0] PLEN_FULL = 8'd128;
	localparam logic [7:0] PLEN_SAT  = 8'd255;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_GROUP = 2'd1,
		STAT_BAD_COUNT = 2'd2,
		STAT_BAD_PFX   = 2'd3
	} status_t;

	// Character classes decided by the front end
	typedef enum logic [1:0] {
		KIND_HEX   = 2'd0,
		KIND_COLON = 2'd1,
		KIND_SLASH = 2'd2,
		KIND_OTHER = 2'd3
	} char_kind_t;

	// One classified character beat
	typedef struct packed {
		char_kind_t kind;
		logic [3:0] nib;     // hex or decimal digit value
		logic       dec;     // character is '0'..'9'
		logic       last;
	} item_t;

endpackage

>>> rtl/ip6tp_front.sv
// Front end: classifies each incoming character into a queue entry.
module ip6tp_front
	import ip6tp_pkg::*;
(
	input  logic [7:0] char_code,
	input  logic       last_char,
	output item_t      item
);

	// Decode character class and digit value
	always_comb begin
		item.kind = KIND_OTHER;
		item.nib  = 4'd0;
		item.dec  = 1'b0;
		item.last = last_char;
		if (char_code inside {[8'h30:8'h39]}) begin
			item.kind = KIND_HEX;
			item.nib  = 4'(char_code - 8'h30);
			item.dec  = 1'b1;
		end else if (char_code inside {[8'h61:8'h66]}) begin
			item.kind = KIND_HEX;
			item.nib  = 4'(char_code - 8'h57);
		end else if (char_code inside {[8'h41:8'h46]}) begin
			item.kind = KIND_HEX;
			item.nib  = 4'(char_code - 8'h37);
		end else if (char_code == 8'h3A) begin
			item.kind = KIND_COLON;
		end else if (char_code == 8'h2F) begin
			item.kind = KIND_SLASH;
		end
	end

endmodule

>>> rtl/ip6tp_queue.sv
// Short queue of classified characters between front and back.
module ip6tp_queue
	import ip6tp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	// Write entry
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

>>> rtl/ip6tp_back.sv
// Back end: runs the parse state per character and registers the result beat.
module ip6tp_back
	import ip6tp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  item_t        head_item,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [63:0]  address_high,
	output logic [63:0]  address_low,
	output logic [7:0]   prefix_length,
	output logic [1:0]   status
);

	// Parse state; group_q is kept in final layout, tail groups right-aligned
	logic [GROUP_W-1:0] group_q [NUM_GROUPS];
	logic [GIDX_W-1:0]  seen_q;
	logic [2:0]         digits_q;
	logic [GROUP_W-1:0] gval_q;
	logic               gap_q;
	logic [GIDX_W-1:0]  gap_idx_q;
	logic [1:0]         colons_q;
	logic               in_pfx_q;
	logic [7:0]         pfx_q;
	logic               pfx_any_q;
	status_t            fault_q;

	logic [GROUP_W-1:0] group_d [NUM_GROUPS];
	logic [GIDX_W-1:0]  seen_d;
	logic [2:0]         digits_d;
	logic [GROUP_W-1:0] gval_d;
	logic               gap_d;
	logic [GIDX_W-1:0]  gap_idx_d;
	logic [1:0]         colons_d;
	logic               in_pfx_d;
	logic [7:0]         pfx_d;
	logic               pfx_any_d;
	status_t            fault_d;

	logic [GROUP_W-1:0] res_group [NUM_GROUPS];
	logic [7:0]         res_plen;
	status_t            res_stat;
	logic [11:0]        pfx_sum;
	logic               fire;
	logic               emit;

	logic               out_valid_q;
	logic [63:0]        addr_hi_q;
	logic [63:0]        addr_lo_q;
	logic [7:0]         plen_q;
	logic [1:0]         stat_q;

	// Take a beat unless it ends a string and the output slot is busy
	assign fire = head_valid && (!head_item.last || !out_valid_q || !out_stall);
	assign pop  = fire;
	assign emit = fire && head_item.last;

	// Next parse state
	always_comb begin
		group_d   = group_q;
		seen_d    = seen_q;
		digits_d  = digits_q;
		gval_d    = gval_q;
		gap_d     = gap_q;
		gap_idx_d = gap_idx_q;
		colons_d  = colons_q;
		in_pfx_d  = in_pfx_q;
		pfx_d     = pfx_q;
		pfx_any_d = pfx_any_q;
		fault_d   = fault_q;
		pfx_sum   = ({4'd0, pfx_q} << 3) + ({4'd0, pfx_q} << 1) + {8'd0, head_item.nib};
		res_plen  = PLEN_FULL;
		res_stat  = STAT_OK;
		for (int j = 0; j < NUM_GROUPS; j++)
			res_group[j] = '0;

		if (fire) begin
			// Character step, skipped once a fault is recorded
			if (fault_d == STAT_OK) begin
				if (in_pfx_d) begin
					if (head_item.dec) begin
						pfx_d     = (pfx_sum > 12'(PLEN_SAT)) ? PLEN_SAT : pfx_sum[7:0];
						pfx_any_d = 1'b1;
					end else begin
						fault_d = STAT_BAD_PFX;
					end
				end else begin
					case (head_item.kind)
						KIND_HEX: begin
							if (digits_d >= 3'd4 ||
							    (colons_d == 2'd1 && seen_d == '0 && !gap_d)) begin
								fault_d = STAT_BAD_GROUP;
							end else begin
								gval_d   = {gval_d[GROUP_W-5:0], head_item.nib};
								digits_d = digits_d + 3'd1;
								colons_d = 2'd0;
							end
						end
						KIND_COLON: begin
							if (digits_d != 3'd0) begin
								// Close the group
								if (seen_d >= GIDX_W'(NUM_GROUPS)) begin
									fault_d = STAT_BAD_COUNT;
								end else begin
									if (!gap_d) begin
										group_d[seen_d[GIDX_W-2:0]] = gval_d;
									end else begin
										for (int j = 0; j < NUM_GROUPS; j++)
											if (GIDX_W'(j) >= gap_idx_d)
												group_d[j] = (j == NUM_GROUPS - 1) ?
													gval_d : group_d[(j + 1) % NUM_GROUPS];
									end
									seen_d = seen_d + GIDX_W'(1);
								end
								gval_d   = '0;
								digits_d = 3'd0;
								colons_d = 2'd1;
							end else if (colons_d == 2'd1) begin
								if (gap_d) begin
									fault_d = STAT_BAD_GROUP;
								end else begin
									gap_d     = 1'b1;
									gap_idx_d = seen_d;
									colons_d  = 2'd2;
								end
							end else if (colons_d == 2'd0) begin
								colons_d = 2'd1;
							end else begin
								fault_d = STAT_BAD_GROUP;
							end
						end
						KIND_SLASH: begin
							in_pfx_d = 1'b1;
						end
						default: begin
							fault_d = STAT_BAD_GROUP;
						end
					endcase
				end
			end

			// Close the address part on a slash, or at the end without a prefix
			if (fault_d == STAT_OK && !in_pfx_q &&
			    ((head_item.kind == KIND_SLASH) || (head_item.last && !in_pfx_d))) begin
				if (digits_d != 3'd0) begin
					if (seen_d >= GIDX_W'(NUM_GROUPS)) begin
						fault_d = STAT_BAD_COUNT;
					end else begin
						if (!gap_d) begin
							group_d[seen_d[GIDX_W-2:0]] = gval_d;
						end else begin
							for (int j = 0; j < NUM_GROUPS; j++)
								if (GIDX_W'(j) >= gap_idx_d)
									group_d[j] = (j == NUM_GROUPS - 1) ?
										gval_d : group_d[(j + 1) % NUM_GROUPS];
						end
						seen_d = seen_d + GIDX_W'(1);
					end
					gval_d   = '0;
					digits_d = 3'd0;
				end else if (colons_d == 2'd1) begin
					fault_d = STAT_BAD_GROUP;
				end
				if (fault_d == STAT_OK) begin
					if (gap_d ? (seen_d > GIDX_W'(NUM_GROUPS - 1))
					          : (seen_d != GIDX_W'(NUM_GROUPS)))
						fault_d = STAT_BAD_COUNT;
				end
			end

			// Finish the string: check prefix, form result, clear state
			if (head_item.last) begin
				if (fault_d == STAT_OK && in_pfx_d && (!pfx_any_d || pfx_d > PLEN_FULL))
					fault_d = STAT_BAD_PFX;
				res_stat = fault_d;
				if (fault_d == STAT_OK) begin
					res_group = group_d;
					if (in_pfx_d && pfx_d != 8'd0)
						res_plen = pfx_d;
				end
				for (int j = 0; j < NUM_GROUPS; j++)
					group_d[j] = '0;
				seen_d    = '0;
				digits_d  = 3'd0;
				gval_d    = '0;
				gap_d     = 1'b0;
				gap_idx_d = '0;
				colons_d  = 2'd0;
				in_pfx_d  = 1'b0;
				pfx_d     = 8'd0;
				pfx_any_d = 1'b0;
				fault_d   = STAT_OK;
			end
		end
	end

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_GROUPS; j++)
				group_q[j] <= '0;
			seen_q    <= '0;
			digits_q  <= 3'd0;
			gval_q    <= '0;
			gap_q     <= 1'b0;
			gap_idx_q <= '0;
			colons_q  <= 2'd0;
			in_pfx_q  <= 1'b0;
			pfx_q     <= 8'd0;
			pfx_any_q <= 1'b0;
			fault_q   <= STAT_OK;
		end else begin
			group_q   <= group_d;
			seen_q    <= seen_d;
			digits_q  <= digits_d;
			gval_q    <= gval_d;
			gap_q     <= gap_d;
			gap_idx_q <= gap_idx_d;
			colons_q  <= colons_d;
			in_pfx_q  <= in_pfx_d;
			pfx_q     <= pfx_d;
			pfx_any_q <= pfx_any_d;
			fault_q   <= fault_d;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (emit) begin
			for (int j = 0; j < HALF_GROUPS; j++) begin
				addr_hi_q[GROUP_W*(HALF_GROUPS-1-j) +: GROUP_W] <= res_group[j];
				addr_lo_q[GROUP_W*(HALF_GROUPS-1-j) +: GROUP_W] <= res_group[j + HALF_GROUPS];
			end
			plen_q <= res_plen;
			stat_q <= res_stat;
		end
	end

	assign out_valid     = out_valid_q;
	assign address_high  = addr_hi_q;
	assign address_low   = addr_lo_q;
	assign prefix_length = plen_q;
	assign status        = stat_q;

endmodule

>>> rtl/ipv6_text_address_parser_unit.sv
// IPv6 text address parser: one character per beat in, one address beat per string out.
// Feed the address text one ASCII character per input beat and mark the final character
// with last_char. A sustained rate of one character per clock is held: the front end
// classifies each character into a two-entry queue, and the back end updates the parse
// state from the queue head once per cycle. The result beat is registered when the back
// end takes the final character from the queue head and sits in an output register,
// so input keeps flowing while the result waits; only when a second string ends with
// the previous result still stalled does the back end pause. address_high holds
// groups 0 to 3 and address_low groups 4 to 7, first group most significant, with the
// first "::" expanded to zeros.
// prefix_length is 128 when no prefix or a zero prefix is given. status is 0 for ok,
// 1 for a bad group, 2 for a wrong group count, 3 for a bad prefix; on any fault the
// address is zero and prefix_length is 128. State clears after every result.
module ipv6_text_address_parser_unit
	import ip6tp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] address_high,
	output logic [63:0] address_low,
	output logic [7:0]  prefix_length,
	output logic [1:0]  status
);

	item_t front_item;
	item_t head_item;
	logic  q_full;
	logic  head_valid;
	logic  pop;

	assign in_stall = q_full;

	ip6tp_front u_front (
		.char_code (char_code),
		.last_char (last_char),
		.item      (front_item)
	);

	ip6tp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !q_full),
		.push_item  (front_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	ip6tp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.address_high  (address_high),
		.address_low   (address_low),
		.prefix_length (prefix_length),
		.status        (status)
	);

endmodule
